// ----- rtl/vna_pkg.sv -----
package vna_pkg;

  // Field widths
  localparam int VIDX_W = 10;
  localparam int POS_W  = 24;
  localparam int SUM_W  = 24;
  localparam int NRM_W  = 16;
  localparam int CRS_W  = 51;   // cross product component, signed
  localparam int SQ_W   = 30;   // component magnitude after scaling
  localparam int RT_W   = 31;   // square root of a sum of three squares

  // Store sizes
  localparam int NVERT    = 1024;
  localparam int MAX_POLY = 8;
  localparam int PL_W     = 3;  // polygon list index
  localparam int FILL_W   = 4;  // polygon fill count, 0..MAX_POLY

  // Command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_POLY  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_DROP = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_VERTEX,
    OP_CLOSE,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [VIDX_W-1:0]      idx;
    logic [POS_W-1:0]       x;
    logic [POS_W-1:0]       y;
    logic [POS_W-1:0]       z;
  } cmd_t;

endpackage

// ----- rtl/vna_in_if.sv -----
interface vna_in_if import vna_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [VIDX_W-1:0]        vert_idx;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic                     last_in_polygon;

  modport source (output valid, kind, vert_idx, pos_x, pos_y, pos_z, last_in_polygon,
                  input ready);
  modport sink (input valid, kind, vert_idx, pos_x, pos_y, pos_z, last_in_polygon,
                output ready);
endinterface

// ----- rtl/vna_out_if.sv -----
interface vna_out_if import vna_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NRM_W-1:0]  normal_x;
  logic signed [NRM_W-1:0]  normal_y;
  logic signed [NRM_W-1:0]  normal_z;
  logic [1:0]               status;
  logic [VIDX_W-1:0]        echo_index;

  modport source (output valid, normal_x, normal_y, normal_z, status, echo_index,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, status, echo_index,
                output ready);
endinterface

// ----- rtl/vna_front.sv -----
module vna_front import vna_pkg::*; (
  vna_in_if.sink     items,
  input  logic       blocked,
  input  logic       full,
  output logic       push,
  output cmd_t       cmd
);

  assign items.ready = !full && !blocked;
  assign push        = items.valid && items.ready;

  // Classify the item into a back-end operation
  always_comb begin
    cmd.idx = items.vert_idx;
    cmd.x   = items.pos_x;
    cmd.y   = items.pos_y;
    cmd.z   = items.pos_z;
    case (kind_t'(items.kind))
      KIND_WRITE: cmd.op = OP_WRITE;
      KIND_POLY:  cmd.op = items.last_in_polygon ? OP_CLOSE : OP_VERTEX;
      KIND_QUERY: cmd.op = OP_QUERY;
      default:    cmd.op = OP_CLEAR;
    endcase
  end

endmodule

// ----- rtl/vna_fifo.sv -----
module vna_fifo import vna_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cmd_t  din,
  output logic  full,
  input  logic  pop,
  output cmd_t  dout,
  output logic  empty
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QDEPTH);
  assign empty = count == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/vna_norm.sv -----
module vna_norm import vna_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [CRS_W-1:0]  cx,
  input  logic signed [CRS_W-1:0]  cy,
  input  logic signed [CRS_W-1:0]  cz,
  output logic                     done,
  output logic                     ok,
  output logic signed [NRM_W-1:0]  nx,
  output logic signed [NRM_W-1:0]  ny,
  output logic signed [NRM_W-1:0]  nz
);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DLOAD, N_DSTEP, N_DONE
  } nstate_t;

  nstate_t              state;
  logic [CRS_W-1:0]     mag [3];
  logic                 sgn [3];
  logic [4:0]           cnt;
  logic [1:0]           comp;
  logic [2*SQ_W-1:0]    sq_prod;
  logic [2*SQ_W+1:0]    acc;
  logic [2*SQ_W+1:0]    rad;
  logic [RT_W-1:0]      root;
  logic [RT_W+2:0]      rem;
  logic [RT_W:0]        drem;
  logic [NRM_W-1:0]     num_lo;
  logic [NRM_W-1:0]     dq;

  logic [SQ_W-1:0]      a_sq;
  logic [SQ_W-1:0]      a_dv;
  logic [RT_W+2:0]      rem_sh;
  logic [RT_W+2:0]      trial;
  logic [SQ_W+14:0]     num;
  logic [RT_W:0]        drem_sh;
  logic                 qbit;
  logic [NRM_W-1:0]     q_next;
  logic                 big;

  assign done = state == N_DONE;

  // Operand selection for the square and divide steps
  always_comb begin
    case (cnt[1:0])
      2'd0:    a_sq = mag[0][SQ_W-1:0];
      2'd1:    a_sq = mag[1][SQ_W-1:0];
      2'd2:    a_sq = mag[2][SQ_W-1:0];
      default: a_sq = '0;
    endcase
    case (comp)
      2'd0:    a_dv = mag[0][SQ_W-1:0];
      2'd1:    a_dv = mag[1][SQ_W-1:0];
      default: a_dv = mag[2][SQ_W-1:0];
    endcase
  end

  // Any component still at or above 2^30
  assign big = (|mag[0][CRS_W-1:SQ_W]) || (|mag[1][CRS_W-1:SQ_W]) ||
               (|mag[2][CRS_W-1:SQ_W]);

  // One root digit per cycle
  assign rem_sh = {rem[RT_W:0], rad[2*SQ_W+1:2*SQ_W]};
  assign trial  = {1'b0, root, 2'b01};

  // Rounded numerator a*16384 + len/2
  assign num = {1'b0, a_dv, 14'b0} + {15'b0, root[RT_W-1:1]};

  // One quotient bit per cycle
  assign drem_sh = {drem[RT_W-1:0], num_lo[NRM_W-1]};
  assign qbit    = drem_sh >= {1'b0, root};
  assign q_next  = {dq[NRM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      ok    <= 1'b0;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            mag[0] <= cx[CRS_W-1] ? CRS_W'(-cx) : CRS_W'(cx);
            mag[1] <= cy[CRS_W-1] ? CRS_W'(-cy) : CRS_W'(cy);
            mag[2] <= cz[CRS_W-1] ? CRS_W'(-cz) : CRS_W'(cz);
            sgn[0] <= cx[CRS_W-1];
            sgn[1] <= cy[CRS_W-1];
            sgn[2] <= cz[CRS_W-1];
            nx     <= '0;
            ny     <= '0;
            nz     <= '0;
            ok     <= 1'b0;
            if (cx == '0 && cy == '0 && cz == '0) state <= N_DONE;
            else                                  state <= N_SHIFT;
          end
        end
        // Scale down until the largest magnitude fits in 30 bits
        N_SHIFT: begin
          if (big) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            cnt   <= '0;
            acc   <= '0;
            state <= N_SQ;
          end
        end
        // Sum of squares, one multiply per cycle
        N_SQ: begin
          sq_prod <= a_sq * a_sq;
          if (cnt != '0) acc <= acc + {2'b0, sq_prod};
          if (cnt == 5'd3) begin
            rad   <= acc + {2'b0, sq_prod};
            root  <= '0;
            rem   <= '0;
            cnt   <= '0;
            state <= N_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        N_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[RT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[RT_W-2:0], 1'b0};
          end
          rad <= rad << 2;
          if (cnt == 5'(RT_W - 1)) begin
            comp  <= '0;
            state <= N_DLOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        // Quotient is below 2^16, so the upper numerator bits start as remainder
        N_DLOAD: begin
          drem   <= (RT_W+1)'(num[SQ_W+14:NRM_W]);
          num_lo <= num[NRM_W-1:0];
          dq     <= '0;
          cnt    <= '0;
          state  <= N_DSTEP;
        end
        N_DSTEP: begin
          drem   <= qbit ? drem_sh - {1'b0, root} : drem_sh;
          dq     <= q_next;
          num_lo <= num_lo << 1;
          if (cnt == 5'(NRM_W - 1)) begin
            case (comp)
              2'd0:    nx <= sgn[0] ? -q_next : q_next;
              2'd1:    ny <= sgn[1] ? -q_next : q_next;
              default: nz <= sgn[2] ? -q_next : q_next;
            endcase
            if (comp == 2'd2) begin
              ok    <= 1'b1;
              state <= N_DONE;
            end else begin
              comp  <= comp + 1'b1;
              state <= N_DLOAD;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        N_DONE:  state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vna_back.sv -----
module vna_back import vna_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  cmd_t       cmd,
  output logic       pop,
  output logic       blocked,
  vna_out_if.source  results
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_QDATA, S_PREAD, S_PDIFF, S_CROSS,
    S_NSTART, S_NWAIT, S_ACC_RD, S_ACC_WR, S_EMIT
  } state_t;

  state_t                   state;
  logic [VIDX_W-1:0]        plist [MAX_POLY];
  logic [FILL_W-1:0]        fill;
  logic                     overflow;
  logic [FILL_W-1:0]        pcount;
  logic [FILL_W-1:0]        ai;
  logic [2:0]               step;
  logic [VIDX_W-1:0]        clr_addr;
  logic                     is_query;
  logic [VIDX_W-1:0]        res_idx;
  logic signed [NRM_W-1:0]  res_x;
  logic signed [NRM_W-1:0]  res_y;
  logic signed [NRM_W-1:0]  res_z;
  status_t                  res_status;

  logic [3*POS_W-1:0]       pos_mem [NVERT];
  logic [3*SUM_W-1:0]       sum_mem [NVERT];
  logic [3*POS_W-1:0]       pos_rd;
  logic [3*SUM_W-1:0]       sum_rd;
  logic [3*POS_W-1:0]       preg [3];

  logic signed [POS_W:0]    u0, u1, u2, v0, v1, v2;
  logic signed [POS_W:0]    ua, vb;
  logic signed [2*POS_W+1:0] prod;
  logic signed [2*POS_W+1:0] hold;
  logic signed [CRS_W-1:0]  nin_x, nin_y, nin_z;
  logic signed [CRS_W-1:0]  cdiff;

  logic [VIDX_W-1:0]        pos_raddr;
  logic [VIDX_W-1:0]        sum_raddr;
  logic                     sum_we;
  logic [VIDX_W-1:0]        sum_waddr;
  logic [3*SUM_W-1:0]       sum_wdata;
  logic                     out_free;
  logic [FILL_W-1:0]        cnt_after;

  logic                     n_start;
  logic                     n_done;
  logic                     n_ok;
  logic signed [NRM_W-1:0]  n_x, n_y, n_z;

  function automatic logic signed [POS_W:0] pdiff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [NRM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {a[SUM_W-1], a} + {{(SUM_W+1-NRM_W){b[NRM_W-1]}}, b};
    if (t[SUM_W] != t[SUM_W-1])
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return t[SUM_W-1:0];
  endfunction

  assign pop      = (state == S_IDLE) && !empty;
  assign blocked  = state == S_INIT;
  assign out_free = !results.valid || results.ready;
  assign n_start  = state == S_NSTART;
  assign cnt_after = (fill < FILL_W'(MAX_POLY)) ? fill + 1'b1 : fill;

  // Indices are 10 bits wide, so every listed vertex is within the store
  assign pos_raddr = plist[PL_W'(step[1:0])];
  assign sum_raddr = (state == S_IDLE) ? cmd.idx : plist[ai[PL_W-1:0]];

  // Accumulator write port: clearing sweep or saturating update
  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = clr_addr;
    sum_wdata = '0;
    case (state)
      S_INIT, S_CLEAR: sum_we = 1'b1;
      S_ACC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = plist[ai[PL_W-1:0]];
        sum_wdata = {sat_add(sum_rd[3*SUM_W-1:2*SUM_W], res_x),
                     sat_add(sum_rd[2*SUM_W-1:SUM_W], res_y),
                     sat_add(sum_rd[SUM_W-1:0], res_z)};
      end
      default: sum_we = 1'b0;
    endcase
  end

  // Cross product operand order: u1v2, u2v1, u2v0, u0v2, u0v1, u1v0
  always_comb begin
    case (step)
      3'd0:    begin ua = u1; vb = v2; end
      3'd1:    begin ua = u2; vb = v1; end
      3'd2:    begin ua = u2; vb = v0; end
      3'd3:    begin ua = u0; vb = v2; end
      3'd4:    begin ua = u0; vb = v1; end
      default: begin ua = u1; vb = v0; end
    endcase
  end

  assign cdiff = CRS_W'(hold) - CRS_W'(prod);

  // Position and accumulator memories
  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_WRITE) pos_mem[cmd.idx] <= {cmd.x, cmd.y, cmd.z};
    pos_rd <= pos_mem[pos_raddr];
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      clr_addr      <= '0;
      fill          <= '0;
      overflow      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_EMIT) results.valid <= 1'b0;
      case (state)
        S_INIT, S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VIDX_W'(NVERT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty) begin
            res_idx <= cmd.idx;
            case (cmd.op)
              OP_VERTEX, OP_CLOSE: begin
                if (fill < FILL_W'(MAX_POLY)) plist[fill[PL_W-1:0]] <= cmd.idx;
                if (cmd.op == OP_CLOSE) begin
                  fill     <= '0;
                  overflow <= 1'b0;
                  pcount   <= cnt_after;
                  is_query <= 1'b0;
                  step     <= '0;
                  if (overflow || fill >= FILL_W'(MAX_POLY) || cnt_after < FILL_W'(3)) begin
                    res_x      <= '0;
                    res_y      <= '0;
                    res_z      <= '0;
                    res_status <= STAT_DROP;
                    state      <= S_EMIT;
                  end else begin
                    state <= S_PREAD;
                  end
                end else if (fill < FILL_W'(MAX_POLY)) begin
                  fill <= fill + 1'b1;
                end else begin
                  overflow <= 1'b1;
                end
              end
              OP_QUERY: begin
                is_query <= 1'b1;
                state    <= S_QDATA;
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_QDATA: begin
          nin_x <= {{(CRS_W-SUM_W){sum_rd[3*SUM_W-1]}}, sum_rd[3*SUM_W-1:2*SUM_W]};
          nin_y <= {{(CRS_W-SUM_W){sum_rd[2*SUM_W-1]}}, sum_rd[2*SUM_W-1:SUM_W]};
          nin_z <= {{(CRS_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd[SUM_W-1:0]};
          state <= S_NSTART;
        end
        // Read the first three listed positions, one per cycle
        S_PREAD: begin
          if (step != '0) preg[step[1:0] - 2'd1] <= pos_rd;
          if (step == 3'd3) state <= S_PDIFF;
          else              step  <= step + 1'b1;
        end
        S_PDIFF: begin
          u0    <= pdiff(preg[0][3*POS_W-1:2*POS_W], preg[1][3*POS_W-1:2*POS_W]);
          u1    <= pdiff(preg[0][2*POS_W-1:POS_W],   preg[1][2*POS_W-1:POS_W]);
          u2    <= pdiff(preg[0][POS_W-1:0],         preg[1][POS_W-1:0]);
          v0    <= pdiff(preg[2][3*POS_W-1:2*POS_W], preg[1][3*POS_W-1:2*POS_W]);
          v1    <= pdiff(preg[2][2*POS_W-1:POS_W],   preg[1][2*POS_W-1:POS_W]);
          v2    <= pdiff(preg[2][POS_W-1:0],         preg[1][POS_W-1:0]);
          step  <= '0;
          state <= S_CROSS;
        end
        // One product per cycle; each pair is subtracted once its second product is registered
        S_CROSS: begin
          prod <= ua * vb;
          hold <= prod;
          case (step)
            3'd2:    nin_x <= cdiff;
            3'd4:    nin_y <= cdiff;
            3'd6:    nin_z <= cdiff;
            default: begin end
          endcase
          if (step == 3'd6) state <= S_NSTART;
          else              step  <= step + 1'b1;
        end
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (n_done) begin
            res_x <= n_x;
            res_y <= n_y;
            res_z <= n_z;
            if (is_query) begin
              res_status <= n_ok ? STAT_OK : STAT_ZERO;
              state      <= S_EMIT;
            end else if (!n_ok) begin
              res_status <= STAT_DROP;
              state      <= S_EMIT;
            end else begin
              res_status <= STAT_OK;
              ai         <= '0;
              state      <= S_ACC_RD;
            end
          end
        end
        // Read-modify-write of each listed accumulator: read in S_ACC_RD, update in S_ACC_WR
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: begin
          ai <= ai + 1'b1;
          if (ai + 1'b1 == pcount) state <= S_EMIT;
          else                     state <= S_ACC_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            results.valid      <= 1'b1;
            results.normal_x   <= res_x;
            results.normal_y   <= res_y;
            results.normal_z   <= res_z;
            results.status     <= res_status;
            results.echo_index <= res_idx;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .cx    (nin_x),
    .cy    (nin_y),
    .cz    (nin_z),
    .done  (n_done),
    .ok    (n_ok),
    .nx    (n_x),
    .ny    (n_y),
    .nz    (n_z)
  );

endmodule

// ----- rtl/vertex_normal_accumulator.sv -----
// Vertex normal accumulator. Position writes and polygon vertices are handled in the
// back end's idle state; queries and polygon closes go through the shared normalizer,
// which scales by one bit per cycle, forms a square root one bit per cycle and divides
// one quotient bit per cycle for each axis, and a close then updates the accumulator of
// each listed vertex. A clear sweeps the 1024-entry accumulator memory; the same sweep
// runs after reset, and no item is accepted during it. A four-entry queue lets the
// input keep accepting items while the back end works, and a result waits in an output
// register until taken.
module vertex_normal_accumulator import vna_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  vna_in_if.sink     items,
  vna_out_if.source  results
);

  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  logic  blocked;
  cmd_t  fcmd;
  cmd_t  bcmd;

  vna_front u_front (
    .items   (items),
    .blocked (blocked),
    .full    (full),
    .push    (push),
    .cmd     (fcmd)
  );

  vna_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (fcmd),
    .full  (full),
    .pop   (pop),
    .dout  (bcmd),
    .empty (empty)
  );

  vna_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .cmd     (bcmd),
    .pop     (pop),
    .blocked (blocked),
    .results (results)
  );

  // Queue is never written while full
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overrun");

  // No item is taken during the clearing sweep after reset
  assert property (@(posedge clk) disable iff (rst) blocked |-> !items.ready)
    else $error("item accepted during reset sweep");

  // A result without ok status carries a zero normal
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != STAT_OK) |->
      (results.normal_x == '0 && results.normal_y == '0 && results.normal_z == '0))
    else $error("nonzero normal on failed result");

  // Normal components stay within unit range
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.normal_x <= 16'sd16384 && results.normal_x >= -16'sd16384 &&
                       results.normal_y <= 16'sd16384 && results.normal_y >= -16'sd16384 &&
                       results.normal_z <= 16'sd16384 && results.normal_z >= -16'sd16384))
    else $error("normal component out of range");

endmodule
